[sv/rhls_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rhls_pkg
// Shared types and constants of the RGB to hue / lightness / saturation
// converter: fixed-point scale, datapath widths and the words handed from
// cell to cell.
// ----------------------------------------------------------------------------
package rhls_pkg;

   // fixed point scale, ONE means 1.0
   localparam int FRACTION_BITS = 16;
   localparam int COMP_W        = 17;
   localparam logic [COMP_W-1:0] ONE = COMP_W'(1) << FRACTION_BITS;

   // square root datapath
   localparam int SQ_W     = 34;             // r^2+g^2+b^2
   localparam int ROOT_W   = 35;             // working root register
   localparam int NORM_W   = 17;             // final norm
   localparam int SQ_STEPS = 17;             // one cell per result bit

   // divider datapath
   localparam int REM_W     = 27;
   localparam int DEN_W     = 18;
   localparam int QUO_W     = 9;
   localparam int DIV_STEPS = QUO_W;
   localparam logic [DEN_W-1:0] LIGHT_DEN = DEN_W'(3) * DEN_W'(ONE);

   // divider lanes
   localparam int LANE_HUE   = 0;
   localparam int LANE_LIGHT = 1;
   localparam int LANE_SAT   = 2;
   localparam int LANES      = 3;

   // output codes and limits
   localparam logic [8:0] HUE_ZERO_COLOR = 9'd240;
   localparam logic [6:0] SAT_CAP        = 7'd100;

   // data that rides along the root chain
   typedef struct packed {
      logic              hue_zero;
      logic [REM_W-1:0]  hue_num;
      logic [DEN_W-1:0]  hue_den;
      logic [REM_W-1:0]  sat_num;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic [SQ_W-1:0]   rem;
      logic [ROOT_W-1:0] root;
      side_type          side;
   } sq_word_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic                      valid;
      logic                      hue_zero;
      logic                      norm_zero;
      lane_type [LANES-1:0]      lane;
   } div_word_type;

endpackage
`default_nettype wire

[sv/rhls_sqrt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rhls_sqrt_cell
// One step of the digit-by-digit integer square root. Each cell settles one
// root bit and hands remainder, partial root and side data to the next cell.
// ----------------------------------------------------------------------------
module rhls_sqrt_cell #(
   parameter int STEP = 0
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   en,
   input  rhls_pkg::sq_word_type in_word,
   output rhls_pkg::sq_word_type out_word
);

   localparam logic [rhls_pkg::ROOT_W-1:0] BIT_VAL =
      rhls_pkg::ROOT_W'(1) << (2 * STEP);

   logic                            valid_ff;
   logic [rhls_pkg::SQ_W-1:0]       rem_ff, rem_in;
   logic [rhls_pkg::ROOT_W-1:0]     root_ff, root_in;
   rhls_pkg::side_type              side_ff;
   logic [rhls_pkg::ROOT_W-1:0]     trial;

   // try subtracting root+bit
   always_comb begin
      trial = in_word.root + BIT_VAL;
      if (rhls_pkg::ROOT_W'(in_word.rem) >= trial) begin
         rem_in  = in_word.rem - trial[rhls_pkg::SQ_W-1:0];
         root_in = (in_word.root >> 1) + BIT_VAL;
      end else begin
         rem_in  = in_word.rem;
         root_in = in_word.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_word.side;
      end
   end

   assign out_word.valid = valid_ff;
   assign out_word.rem   = rem_ff;
   assign out_word.root  = root_ff;
   assign out_word.side  = side_ff;

endmodule
`default_nettype wire

[sv/rhls_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rhls_div_cell
// One restoring-division step for all three lanes (hue, lightness,
// saturation). Settles quotient bit STEP of each lane.
// ----------------------------------------------------------------------------
module rhls_div_cell #(
   parameter int STEP = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    en,
   input  rhls_pkg::div_word_type in_word,
   output rhls_pkg::div_word_type out_word
);

   logic                   valid_ff;
   rhls_pkg::div_word_type word_ff, word_in;
   logic [rhls_pkg::REM_W-1:0] shifted [rhls_pkg::LANES];

   // compare against the shifted divisor in each lane
   always_comb begin
      word_in = in_word;
      for (int i = 0; i < rhls_pkg::LANES; i++) begin
         shifted[i] = rhls_pkg::REM_W'(in_word.lane[i].den) << STEP;
         if (in_word.lane[i].rem >= shifted[i]) begin
            word_in.lane[i].rem       = in_word.lane[i].rem - shifted[i];
            word_in.lane[i].quo[STEP] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_word.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   always_comb begin
      out_word       = word_ff;
      out_word.valid = valid_ff;
   end

endmodule
`default_nettype wire

[sv/rgb_to_hue_lightness_saturation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hue_lightness_saturation
// Converts one RGB word into hue, lightness and saturation.
//
// Usage:
//   Request channel req_valid/req_stall carries red, green, blue (unsigned,
//   65536 = 1.0, larger values clamp). Response channel rsp_valid/rsp_stall
//   carries hue (0..360), lightness (0..57) and saturation (0..100).
//   A word is taken on an edge with valid high and stall low.
//   Throughput: one word per cycle while req_stall is low, set by the row
//   of cells: 17 square-root cells (one root bit each) and 9 divider cells
//   (one quotient bit each, three lanes side by side).
//   Path from request acceptance to rsp_valid: input register, squares,
//   sums, 17 root cells, 9 divider cells, output register.
//   When the receiver stalls, the output word holds and one more word lands
//   in a skid register; req_stall is then raised and the whole row freezes
//   until the skid word moves out. req_stall comes from a register only.
//   Reset (synchronous, active high) empties the pipeline and the output;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_to_hue_lightness_saturation (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_stall,
   input  wire [16:0] req_red,
   input  wire [16:0] req_green,
   input  wire [16:0] req_blue,
   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic [8:0] rsp_hue,
   output logic [5:0] rsp_lightness,
   output logic [6:0] rsp_saturation
);

   localparam int CW = rhls_pkg::COMP_W;
   localparam int RW = rhls_pkg::REM_W;
   localparam int DW = rhls_pkg::DEN_W;

   logic en;

   // ---------------- stage 0: clamp and register inputs
   logic          s0_valid_ff;
   logic [CW-1:0] s0_r_ff, s0_g_ff, s0_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_r_ff <= (req_red   > rhls_pkg::ONE) ? rhls_pkg::ONE : req_red;
         s0_g_ff <= (req_green > rhls_pkg::ONE) ? rhls_pkg::ONE : req_green;
         s0_b_ff <= (req_blue  > rhls_pkg::ONE) ? rhls_pkg::ONE : req_blue;
      end
   end

   // ---------------- stage 1: squares, differences squared, hue terms
   logic          s1_valid_ff;
   logic [32:0]   s1_rr_ff, s1_gg_ff, s1_bb_ff;
   logic [32:0]   s1_drg_ff, s1_drb_ff, s1_dgb_ff;
   logic [RW-1:0] s1_hnum_ff, hnum_in;
   logic [DW-1:0] s1_hden_ff, hden_in;
   logic [CW-1:0] d_rg, d_rb, d_gb;

   always_comb begin
      d_rg = (s0_r_ff > s0_g_ff) ? s0_r_ff - s0_g_ff : s0_g_ff - s0_r_ff;
      d_rb = (s0_r_ff > s0_b_ff) ? s0_r_ff - s0_b_ff : s0_b_ff - s0_r_ff;
      d_gb = (s0_g_ff > s0_b_ff) ? s0_g_ff - s0_b_ff : s0_b_ff - s0_g_ff;
   end

   // minimum pick: r, then g if strictly smaller, then b if strictly smaller
   always_comb begin
      logic [CW-1:0] minv;
      logic [1:0]    which;
      minv  = s0_r_ff;
      which = 2'd0;
      if (s0_g_ff < minv) begin
         minv  = s0_g_ff;
         which = 2'd1;
      end
      if (s0_b_ff < minv) begin
         which = 2'd2;
      end
      case (which)
         2'd2: begin
            hnum_in = RW'(240) * RW'(s0_g_ff) + RW'(120) * RW'(s0_r_ff);
            hden_in = DW'(s0_g_ff) + DW'(s0_r_ff);
         end
         2'd1: begin
            hnum_in = RW'(120) * RW'(s0_r_ff);
            hden_in = DW'(s0_r_ff) + DW'(s0_b_ff);
         end
         default: begin
            hnum_in = RW'(240) * RW'(s0_g_ff) + RW'(360) * RW'(s0_b_ff);
            hden_in = DW'(s0_g_ff) + DW'(s0_b_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_rr_ff   <= 33'(s0_r_ff) * 33'(s0_r_ff);
         s1_gg_ff   <= 33'(s0_g_ff) * 33'(s0_g_ff);
         s1_bb_ff   <= 33'(s0_b_ff) * 33'(s0_b_ff);
         s1_drg_ff  <= 33'(d_rg) * 33'(d_rg);
         s1_drb_ff  <= 33'(d_rb) * 33'(d_rb);
         s1_dgb_ff  <= 33'(d_gb) * 33'(d_gb);
         s1_hnum_ff <= hnum_in;
         s1_hden_ff <= hden_in;
      end
   end

   // ---------------- stage 2: sums
   logic                     s2_valid_ff;
   logic [rhls_pkg::SQ_W-1:0] s2_sq_ff;
   logic [34:0]              s2_s_ff;
   logic [RW-1:0]            s2_hnum_ff;
   logic [DW-1:0]            s2_hden_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sq_ff   <= rhls_pkg::SQ_W'(s1_rr_ff) + rhls_pkg::SQ_W'(s1_gg_ff)
                       + rhls_pkg::SQ_W'(s1_bb_ff);
         s2_s_ff    <= 35'(s1_drg_ff) + 35'(s1_drb_ff) + 35'(s1_dgb_ff);
         s2_hnum_ff <= s1_hnum_ff;
         s2_hden_ff <= s1_hden_ff;
      end
   end

   // ---------------- square root chain
   rhls_pkg::sq_word_type sq_w [rhls_pkg::SQ_STEPS+1];
   logic [41:0]           s_x100;

   // saturation numerator: floor(100*S / ONE)
   always_comb begin
      s_x100 = (42'(s2_s_ff) << 6) + (42'(s2_s_ff) << 5) + (42'(s2_s_ff) << 2);
      sq_w[0].valid         = s2_valid_ff;
      sq_w[0].rem           = s2_sq_ff;
      sq_w[0].root          = '0;
      sq_w[0].side.hue_zero = (s2_hden_ff == '0);
      sq_w[0].side.hue_num  = s2_hnum_ff;
      sq_w[0].side.hue_den  = s2_hden_ff;
      sq_w[0].side.sat_num  = RW'(s_x100[41:rhls_pkg::FRACTION_BITS]);
   end

   for (genvar k = 0; k < rhls_pkg::SQ_STEPS; k++) begin : g_sqrt
      rhls_sqrt_cell #(.STEP(rhls_pkg::SQ_STEPS - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_word  (sq_w[k]),
         .out_word (sq_w[k+1])
      );
   end

   // ---------------- divider chain
   rhls_pkg::div_word_type    dv_w [rhls_pkg::DIV_STEPS+1];
   logic [rhls_pkg::NORM_W-1:0] norm;

   always_comb begin
      norm = sq_w[rhls_pkg::SQ_STEPS].root[rhls_pkg::NORM_W-1:0];
      dv_w[0].valid     = sq_w[rhls_pkg::SQ_STEPS].valid;
      dv_w[0].hue_zero  = sq_w[rhls_pkg::SQ_STEPS].side.hue_zero;
      dv_w[0].norm_zero = (norm == '0);
      dv_w[0].lane[rhls_pkg::LANE_HUE].rem  = sq_w[rhls_pkg::SQ_STEPS].side.hue_num;
      dv_w[0].lane[rhls_pkg::LANE_HUE].den  = sq_w[rhls_pkg::SQ_STEPS].side.hue_den;
      dv_w[0].lane[rhls_pkg::LANE_HUE].quo  = '0;
      dv_w[0].lane[rhls_pkg::LANE_LIGHT].rem =
         (RW'(norm) << 6) + (RW'(norm) << 5) + (RW'(norm) << 2);
      dv_w[0].lane[rhls_pkg::LANE_LIGHT].den = rhls_pkg::LIGHT_DEN;
      dv_w[0].lane[rhls_pkg::LANE_LIGHT].quo = '0;
      dv_w[0].lane[rhls_pkg::LANE_SAT].rem  = sq_w[rhls_pkg::SQ_STEPS].side.sat_num;
      dv_w[0].lane[rhls_pkg::LANE_SAT].den  = DW'(norm);
      dv_w[0].lane[rhls_pkg::LANE_SAT].quo  = '0;
   end

   for (genvar k = 0; k < rhls_pkg::DIV_STEPS; k++) begin : g_div
      rhls_div_cell #(.STEP(rhls_pkg::DIV_STEPS - 1 - k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_word  (dv_w[k]),
         .out_word (dv_w[k+1])
      );
   end

   // ---------------- final word
   rhls_pkg::div_word_type fin;
   logic       p_valid;
   logic [8:0] p_hue;
   logic [5:0] p_light;
   logic [6:0] p_sat;
   logic [8:0] sat_q;

   always_comb begin
      fin     = dv_w[rhls_pkg::DIV_STEPS];
      p_valid = fin.valid;
      p_hue   = fin.hue_zero ? rhls_pkg::HUE_ZERO_COLOR
                             : fin.lane[rhls_pkg::LANE_HUE].quo;
      p_light = fin.lane[rhls_pkg::LANE_LIGHT].quo[5:0];
      sat_q   = fin.lane[rhls_pkg::LANE_SAT].quo;
      if (fin.norm_zero) begin
         p_sat = '0;
      end else if (sat_q > 9'(rhls_pkg::SAT_CAP)) begin
         p_sat = rhls_pkg::SAT_CAP;
      end else begin
         p_sat = sat_q[6:0];
      end
   end

   // ---------------- output register and skid
   logic       out_valid_ff;
   logic [8:0] out_hue_ff;
   logic [5:0] out_light_ff;
   logic [6:0] out_sat_ff;
   logic       skid_valid_ff;
   logic [8:0] skid_hue_ff;
   logic [5:0] skid_light_ff;
   logic [6:0] skid_sat_ff;
   logic       out_take;

   assign en       = !skid_valid_ff;
   assign out_take = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= p_valid;
         end
      end else if (!skid_valid_ff && p_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         if (skid_valid_ff) begin
            out_hue_ff   <= skid_hue_ff;
            out_light_ff <= skid_light_ff;
            out_sat_ff   <= skid_sat_ff;
         end else begin
            out_hue_ff   <= p_hue;
            out_light_ff <= p_light;
            out_sat_ff   <= p_sat;
         end
      end else if (!skid_valid_ff) begin
         skid_hue_ff   <= p_hue;
         skid_light_ff <= p_light;
         skid_sat_ff   <= p_sat;
      end
   end

   assign req_stall      = skid_valid_ff;
   assign rsp_valid      = out_valid_ff;
   assign rsp_hue        = out_hue_ff;
   assign rsp_lightness  = out_light_ff;
   assign rsp_saturation = out_sat_ff;

   // ---------------- checks
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   a_skid_moves: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid word not moved to output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !skid_valid_ff))
      else $error("output not empty after reset");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hue <= 9'd360 && rsp_saturation <= rhls_pkg::SAT_CAP
                     && rsp_lightness <= 6'd57))
      else $error("result word out of range");

endmodule
`default_nettype wire
